FILE: rtl/psdes_pkg.sv
`timescale 1ns / 1ps

package psdes_pkg;

  localparam int NUM_ROUNDS_DEF = 4;
  localparam int WORD_W         = 32;
  localparam int HALF_W         = 16;
  localparam int FRAC_W         = 23;

  localparam logic [WORD_W-1:0] SEED_RESET = 32'd1337;

  localparam logic [WORD_W-1:0] KEY_A [4] = '{
    32'hbaa96887, 32'h1e17d32c, 32'h03bcdc3c, 32'h0f33d1b2
  };
  localparam logic [WORD_W-1:0] KEY_B [4] = '{
    32'h4b0f3b58, 32'he874f0c3, 32'h6955c5a6, 32'h55a7ca46
  };

  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] left;
    logic [WORD_W-1:0] right;
  } psdes_link_t;

endpackage

FILE: rtl/psdes_round.sv
`timescale 1ns / 1ps

module psdes_round #(
  parameter int ROUND_IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  psdes_pkg::psdes_link_t link_i,
  output psdes_pkg::psdes_link_t link_o
);
  import psdes_pkg::*;

  localparam logic [WORD_W-1:0] KA = KEY_A[ROUND_IDX % 4];
  localparam logic [WORD_W-1:0] KB = KEY_B[ROUND_IDX % 4];

  logic [WORD_W-1:0] x;
  logic [HALF_W-1:0] lo;
  logic [HALF_W-1:0] hi;
  logic [WORD_W-1:0] p_ll_nxt;
  logic [WORD_W-1:0] p_hh_nxt;
  logic [WORD_W-1:0] p_lh_nxt;

  logic              v1_r;
  logic [WORD_W-1:0] left1_r;
  logic [WORD_W-1:0] right1_r;
  logic [WORD_W-1:0] p_ll_r;
  logic [WORD_W-1:0] p_hh_r;
  logic [WORD_W-1:0] p_lh_r;

  logic [WORD_W-1:0] sq;
  logic [WORD_W-1:0] rot;
  logic [WORD_W-1:0] f;

  psdes_link_t link_r;
  psdes_link_t link_nxt;

  assign x  = link_i.right ^ KA;
  assign lo = x[HALF_W-1:0];
  assign hi = x[WORD_W-1:HALF_W];

  assign p_ll_nxt = WORD_W'(lo) * WORD_W'(lo);
  assign p_hh_nxt = WORD_W'(hi) * WORD_W'(hi);
  assign p_lh_nxt = WORD_W'(lo) * WORD_W'(hi);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= link_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    left1_r  <= link_i.left;
    right1_r <= link_i.right;
    p_ll_r   <= p_ll_nxt;
    p_hh_r   <= p_hh_nxt;
    p_lh_r   <= p_lh_nxt;
  end

  assign sq  = p_ll_r + ~p_hh_r;
  assign rot = {sq[HALF_W-1:0], sq[WORD_W-1:HALF_W]};
  assign f   = (rot ^ KB) + p_lh_r;

  always_comb begin
    link_nxt.valid = v1_r;
    link_nxt.left  = right1_r;
    link_nxt.right = left1_r ^ f;
  end

  always_ff @(posedge clk) begin
    link_r.left  <= link_nxt.left;
    link_r.right <= link_nxt.right;
    if (!rst_n) begin
      link_r.valid <= 1'b0;
    end else begin
      link_r.valid <= link_nxt.valid;
    end
  end

  assign link_o = link_r;

endmodule

FILE: rtl/psdes_counter_hash_rng.sv
`timescale 1ns / 1ps
// Counter-based random generator: four pseudo-DES rounds over (seed, index).
// Input: pulse start with in_sequence_index; the item is taken when start is
//   high and busy is low. busy is always low, so one item can enter per cycle.
// Output: out_valid strobes for one cycle with out_hash_word and
//   out_uniform_fraction (low 23 bits of the hash, units of 2^-23). Results
//   come out in input order; the receiver cannot stall and must take each one.
// Rounds: each round is one cell of two register stages: three 16x16
//   products, then the add/swap/xor mix.
// Throughput: one item per cycle, set by the fully pipelined round chain.
// Configuration: cfg_wr_en with cfg_wr_data writes the seed word; write it
//   only while no items are in flight.
// Reset: rst_n (synchronous, active low) clears all in-flight items and sets
//   the seed word to 1337.

module psdes_counter_hash_rng #(
  parameter int NUM_ROUNDS = psdes_pkg::NUM_ROUNDS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [psdes_pkg::WORD_W-1:0]           in_sequence_index,
  output logic                                   out_valid,
  output logic [psdes_pkg::WORD_W-1:0]           out_hash_word,
  output logic [psdes_pkg::FRAC_W-1:0]           out_uniform_fraction,
  input  logic                                   cfg_wr_en,
  input  logic [psdes_pkg::WORD_W-1:0]           cfg_wr_data
);
  import psdes_pkg::*;

  logic [WORD_W-1:0] seed_r;
  psdes_link_t       chain [NUM_ROUNDS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else if (cfg_wr_en) begin
      seed_r <= cfg_wr_data;
    end
  end

  assign busy = 1'b0;

  always_comb begin
    chain[0].valid = start & ~busy;
    chain[0].left  = seed_r;
    chain[0].right = in_sequence_index;
  end

  for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
    psdes_round #(
      .ROUND_IDX(g)
    ) u_round (
      .clk   (clk),
      .rst_n (rst_n),
      .link_i(chain[g]),
      .link_o(chain[g+1])
    );
  end

  assign out_valid            = chain[NUM_ROUNDS].valid;
  assign out_hash_word        = chain[NUM_ROUNDS].right;
  assign out_uniform_fraction = chain[NUM_ROUNDS].right[FRAC_W-1:0];

endmodule

FILE: rtl/psdes_chk.sv
`timescale 1ns / 1ps

module psdes_chk #(
  parameter int LAT = 2 * psdes_pkg::NUM_ROUNDS_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic [psdes_pkg::WORD_W-1:0] out_hash_word,
  input logic [psdes_pkg::FRAC_W-1:0] out_uniform_fraction
);
  import psdes_pkg::*;

  a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted item produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without an accepted item");

  a_frac_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_uniform_fraction == out_hash_word[FRAC_W-1:0]))
    else $error("fraction does not match hash word");

endmodule

bind psdes_counter_hash_rng psdes_chk #(
  .LAT(2 * NUM_ROUNDS)
) u_psdes_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_valid           (out_valid),
  .out_hash_word       (out_hash_word),
  .out_uniform_fraction(out_uniform_fraction)
);
